// ----- rtl/core/fir16_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fir16_pkg
// Shared types and constants of the 16-bit PCM FIR filter: word layout,
// controller states and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package fir16_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int INDEX_W  = 6;
  localparam int TAPCNT_W = 7;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Input word layout, lowest bit first.
  localparam int IDX_LSB  = 0;
  localparam int COEF_LSB = IDX_LSB + INDEX_W;
  localparam int SMP_LSB  = COEF_LSB + COEF_W;

  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = TAPCNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic coef_wr;
    logic smp_start;
    logic tap_issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic no_taps;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage : fir16_pkg
`default_nettype wire

// ----- rtl/core/fir16_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fir16_ctrl
// Sequencer of the FIR filter: takes input words, starts a sample, issues
// one tap per cycle, waits for the multiply pipeline to drain and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module fir16_ctrl
  import fir16_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_axis_tvalid,
  input  wire logic    s_axis_tuser,
  output logic         s_axis_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_axis_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (s_axis_tuser == CMD_SAMPLE)) begin
          state_next = sts.no_taps ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.coef_wr   = accept && (s_axis_tuser == CMD_COEF);
        cmd.smp_start = accept && (s_axis_tuser == CMD_SAMPLE);
      end
      ST_RUN: begin
        cmd.tap_issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule : fir16_ctrl
`default_nettype wire

// ----- rtl/core/fir16_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fir16_dp
// Datapath of the FIR filter: coefficient and history memories, tap
// pointers, one shared multiplier with an accumulator, the truncation
// toward zero and the output register.
// ----------------------------------------------------------------------------
module fir16_dp
  import fir16_pkg::*;
#(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [TAPCNT_W-1:0]   cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic                       out_ovf
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = PROD_W + AW + 1;
  localparam int RES_W = ACC_W - COEF_FRAC_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_TAPS);

  logic [TAPCNT_W-1:0]      tap_count;
  logic [CW-1:0]            taps;

  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];

  logic [INDEX_W-1:0]         in_idx;
  logic signed [COEF_W-1:0]   in_coef;
  logic signed [SAMPLE_W-1:0] in_smp;

  logic [AW-1:0] wptr;
  logic [AW-1:0] wptr_next;
  logic [CW-1:0] fill;
  logic [AW-1:0] rptr;
  logic [CW-1:0] tap_idx;

  logic                       s1_v;
  logic                       s1_ok;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [SAMPLE_W-1:0] hist_op;
  logic                       p_v;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [RES_W-1:0]    res;
  logic [RES_W-16:0]          res_top;

  assign in_idx  = in_data[IDX_LSB +: INDEX_W];
  assign in_coef = in_data[COEF_LSB +: COEF_W];
  assign in_smp  = in_data[SMP_LSB +: SAMPLE_W];

  // Tap counts above the memory depth saturate.
  assign taps = (32'(tap_count) > MAX_TAPS) ? FULL_CNT : CW'(tap_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAPCNT_RESET;
    end else if (cfg_wen) begin
      tap_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (32'(in_idx) < MAX_TAPS)) begin
      coef_mem[AW'(in_idx)] <= in_coef;
    end
  end

  // The history is a circular buffer; wptr marks the newest sample.
  assign wptr_next = (wptr == LAST_ADDR) ? '0 : wptr + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.smp_start) begin
      hist_mem[wptr_next] <= in_smp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_issue) begin
      coef_q <= coef_mem[tap_idx[AW-1:0]];
      hist_q <= hist_mem[rptr];
    end
  end

  // Entries at or beyond the fill count were never written since reset and
  // read as zero, which stands in for clearing the history.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      fill <= '0;
    end else if (cmd.smp_start) begin
      wptr <= wptr_next;
      fill <= (fill < FULL_CNT) ? fill + CW'(1) : fill;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_start) begin
      rptr    <= wptr_next;
      tap_idx <= '0;
    end else if (cmd.tap_issue) begin
      rptr    <= (rptr == '0) ? LAST_ADDR : rptr - AW'(1);
      tap_idx <= tap_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_issue) begin
      s1_ok <= tap_idx < fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      p_v  <= 1'b0;
    end else begin
      s1_v <= cmd.tap_issue;
      p_v  <= s1_v;
    end
  end

  assign hist_op = s1_ok ? hist_q : '0;

  always_ff @(posedge clk) begin
    prod <= coef_q * hist_op;
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_start) begin
      acc <= '0;
    end else if (p_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Adding the fraction mask to a negative sum makes the arithmetic shift
  // round toward zero.
  assign acc_adj = acc + (acc[ACC_W-1] ? ACC_W'((1 << COEF_FRAC_BITS) - 1) : '0);
  assign res     = RES_W'(acc_adj >>> COEF_FRAC_BITS);
  assign res_top = res[RES_W-1:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res[OUT_DATA_W-1:0];
      out_ovf  <= !((&res_top) || (~|res_top));
    end
  end

  assign sts.no_taps   = (taps == '0);
  assign sts.last_tap  = ((tap_idx + CW'(1)) == taps);
  assign sts.pipe_busy = s1_v || p_v;
  assign sts.out_free  = !out_valid || out_ready;

endmodule : fir16_dp
`default_nettype wire

// ----- rtl/core/fir_filter_16bit_pcm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_16bit_pcm
// Direct-form FIR filter over signed 16-bit PCM samples with Q1.15
// coefficients, one shared multiply-accumulate stepping through the taps.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid tready tdata tuser      coefficient or sample
//  m_axis    out        tvalid tready tdata tuser      filtered sample, flag
//  cfg       in         cfg_wen cfg_wdata              tap count
//
//  A coefficient word with an index below MAX_TAPS is written as it is taken.
//  A sample word is stored, its taps step in turn through the single
//  multiplier and the two memory read ports, the multiply pipeline drains,
//  then the output register is loaded. Tap counts above MAX_TAPS count as
//  MAX_TAPS, and a tap count of zero goes straight to the output load.
//  The output register lets the next word enter while a result waits; a
//  stall on m_axis holds the block at the end of the following sample.
//  Reset clears the history, the tap count returns to one, and coefficients
//  must be written again before samples flow.
// ----------------------------------------------------------------------------
module fir_filter_16bit_pcm
  import fir16_pkg::*;
#(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [TAPCNT_W-1:0]   cfg_wdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // coef_index[5:0], coef_value[21:6], sample_in[37:22], zero[39:38]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // sample_out[15:0]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // overflow[0]
  output logic                       m_axis_tuser
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fir16_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  fir16_dp #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_ovf   (m_axis_tuser)
  );

endmodule : fir_filter_16bit_pcm
`default_nettype wire
